/* hdl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define PTPP_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// When the antecedent holds, the consequent must hold in the next cycle.
`define PTPP_ASSERT_NEXT(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) else $error(msg);

`endif

/* hdl/ptpp_pkg.sv */
// ----------------------------------------------------------------------------
// ptpp_pkg
// Types and constants shared by the projection controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package ptpp_pkg;

   localparam int unsigned POS_BITS  = 17;
   localparam int unsigned RSP_W     = 24;
   localparam logic [16:0] POS_ONE   = 17'h10000;
   localparam logic [15:0] ROUND_Q16 = 16'h8000;
   localparam int unsigned MAC_STEPS  = 4;
   localparam int unsigned FRAC_STEPS = 16;
   localparam int unsigned DIV_STEPS  = 17;

   typedef enum logic [4:0] {
      S_IDLE,
      S_CLEAR,
      S_RDA,
      S_RDB,
      S_LOAD,
      S_L2,
      S_SQRT_INIT,
      S_SQRT,
      S_DOT,
      S_T_INIT,
      S_FRAC,
      S_SCALE,
      S_D2,
      S_TLEN,
      S_CMP,
      S_NEXT,
      S_DIV_INIT,
      S_DIV,
      S_DONE
   } state_type;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_QUERY,
      OP_VERTEX,
      OP_CLEAR,
      OP_LATCH_A,
      OP_LOAD,
      OP_MAC,
      OP_SQRT_INIT,
      OP_SQRT_STEP,
      OP_T_INIT,
      OP_FRAC_STEP,
      OP_TLEN,
      OP_COMPARE,
      OP_NEXT,
      OP_DIV_INIT,
      OP_DIV_STEP,
      OP_OUT
   } dp_op_type;

   typedef enum logic [1:0] {
      MAC_L2,
      MAC_DOT,
      MAC_SCALE,
      MAC_D2
   } mac_type;

   typedef struct packed {
      dp_op_type   op;
      mac_type     mac;
      logic [1:0]  lane;
   } cmd_type;

   typedef struct packed {
      logic l2_zero;
      logic frac_needed;
      logic out_free;
   } status_type;

endpackage

`default_nettype wire

/* hdl/ptpp_ctrl.sv */
// ----------------------------------------------------------------------------
// ptpp_ctrl
// Sequencer for the projection: takes transactions, walks the segments.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module ptpp_ctrl #(
   parameter int NUM_SEGMENTS = 3,
   parameter int SQRT_STEPS   = 25,
   localparam int NUM_VERTS   = NUM_SEGMENTS + 1,
   localparam int AW          = $clog2(NUM_VERTS)
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   input  wire logic                 req_mode,
   output logic                      req_ready,
   input  wire ptpp_pkg::status_type status,
   output ptpp_pkg::cmd_type         cmd,
   output logic [AW-1:0]             wr_addr,
   output logic [AW-1:0]             rd_addr
);

   localparam int MAX_STEPS = (SQRT_STEPS > ptpp_pkg::DIV_STEPS) ?
                              SQRT_STEPS : ptpp_pkg::DIV_STEPS;
   localparam int SW        = $clog2(MAX_STEPS);

   ptpp_pkg::state_type state_ff, state_in;
   logic [SW-1:0]       step_ff, step_in;
   logic [AW-1:0]       seg_ff, seg_in;
   logic [AW-1:0]       vcount_ff, vcount_in;
   logic                last_vertex;
   logic                seg_last;
   logic                mac_last;

   assign last_vertex = (vcount_ff == AW'(NUM_VERTS - 1));
   assign seg_last    = (seg_ff == AW'(NUM_SEGMENTS - 1));
   assign mac_last    = (step_ff == SW'(ptpp_pkg::MAC_STEPS - 1));

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ptpp_pkg::S_IDLE: begin
            if (req_valid && req_mode && last_vertex) state_in = ptpp_pkg::S_CLEAR;
         end
         ptpp_pkg::S_CLEAR:     state_in = ptpp_pkg::S_RDA;
         ptpp_pkg::S_RDA:       state_in = ptpp_pkg::S_RDB;
         ptpp_pkg::S_RDB:       state_in = ptpp_pkg::S_LOAD;
         ptpp_pkg::S_LOAD:      state_in = ptpp_pkg::S_L2;
         ptpp_pkg::S_L2: begin
            if (mac_last) state_in = ptpp_pkg::S_SQRT_INIT;
         end
         ptpp_pkg::S_SQRT_INIT: state_in = ptpp_pkg::S_SQRT;
         ptpp_pkg::S_SQRT: begin
            if (step_ff == SW'(SQRT_STEPS - 1)) begin
               state_in = status.l2_zero ? ptpp_pkg::S_NEXT : ptpp_pkg::S_DOT;
            end
         end
         ptpp_pkg::S_DOT: begin
            if (mac_last) state_in = ptpp_pkg::S_T_INIT;
         end
         ptpp_pkg::S_T_INIT: begin
            state_in = status.frac_needed ? ptpp_pkg::S_FRAC : ptpp_pkg::S_SCALE;
         end
         ptpp_pkg::S_FRAC: begin
            if (step_ff == SW'(ptpp_pkg::FRAC_STEPS - 1)) state_in = ptpp_pkg::S_SCALE;
         end
         ptpp_pkg::S_SCALE: begin
            if (mac_last) state_in = ptpp_pkg::S_D2;
         end
         ptpp_pkg::S_D2: begin
            if (mac_last) state_in = ptpp_pkg::S_TLEN;
         end
         ptpp_pkg::S_TLEN:      state_in = ptpp_pkg::S_CMP;
         ptpp_pkg::S_CMP:       state_in = ptpp_pkg::S_NEXT;
         ptpp_pkg::S_NEXT: begin
            state_in = seg_last ? ptpp_pkg::S_DIV_INIT : ptpp_pkg::S_RDA;
         end
         ptpp_pkg::S_DIV_INIT:  state_in = ptpp_pkg::S_DIV;
         ptpp_pkg::S_DIV: begin
            if (step_ff == SW'(ptpp_pkg::DIV_STEPS - 1)) state_in = ptpp_pkg::S_DONE;
         end
         ptpp_pkg::S_DONE: begin
            if (status.out_free) state_in = ptpp_pkg::S_IDLE;
         end
         default:               state_in = ptpp_pkg::S_IDLE;
      endcase
   end

   // Outputs to the datapath.
   always_comb begin
      cmd.op    = ptpp_pkg::OP_NONE;
      cmd.mac   = ptpp_pkg::MAC_L2;
      cmd.lane  = step_ff[1:0];
      req_ready = 1'b0;
      wr_addr   = vcount_ff;
      rd_addr   = seg_ff;
      unique case (state_ff)
         ptpp_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) cmd.op = req_mode ? ptpp_pkg::OP_VERTEX : ptpp_pkg::OP_QUERY;
         end
         ptpp_pkg::S_CLEAR:     cmd.op = ptpp_pkg::OP_CLEAR;
         ptpp_pkg::S_RDA:       cmd.op = ptpp_pkg::OP_NONE;
         ptpp_pkg::S_RDB: begin
            cmd.op  = ptpp_pkg::OP_LATCH_A;
            rd_addr = seg_ff + AW'(1);
         end
         ptpp_pkg::S_LOAD:      cmd.op = ptpp_pkg::OP_LOAD;
         ptpp_pkg::S_L2: begin
            cmd.op  = ptpp_pkg::OP_MAC;
            cmd.mac = ptpp_pkg::MAC_L2;
         end
         ptpp_pkg::S_SQRT_INIT: cmd.op = ptpp_pkg::OP_SQRT_INIT;
         ptpp_pkg::S_SQRT:      cmd.op = ptpp_pkg::OP_SQRT_STEP;
         ptpp_pkg::S_DOT: begin
            cmd.op  = ptpp_pkg::OP_MAC;
            cmd.mac = ptpp_pkg::MAC_DOT;
         end
         ptpp_pkg::S_T_INIT:    cmd.op = ptpp_pkg::OP_T_INIT;
         ptpp_pkg::S_FRAC:      cmd.op = ptpp_pkg::OP_FRAC_STEP;
         ptpp_pkg::S_SCALE: begin
            cmd.op  = ptpp_pkg::OP_MAC;
            cmd.mac = ptpp_pkg::MAC_SCALE;
         end
         ptpp_pkg::S_D2: begin
            cmd.op  = ptpp_pkg::OP_MAC;
            cmd.mac = ptpp_pkg::MAC_D2;
         end
         ptpp_pkg::S_TLEN:      cmd.op = ptpp_pkg::OP_TLEN;
         ptpp_pkg::S_CMP:       cmd.op = ptpp_pkg::OP_COMPARE;
         ptpp_pkg::S_NEXT:      cmd.op = ptpp_pkg::OP_NEXT;
         ptpp_pkg::S_DIV_INIT:  cmd.op = ptpp_pkg::OP_DIV_INIT;
         ptpp_pkg::S_DIV:       cmd.op = ptpp_pkg::OP_DIV_STEP;
         ptpp_pkg::S_DONE: begin
            if (status.out_free) cmd.op = ptpp_pkg::OP_OUT;
         end
         default:               cmd.op = ptpp_pkg::OP_NONE;
      endcase
   end

   // Counters.
   always_comb begin
      step_in   = (state_in == state_ff) ? step_ff + SW'(1) : '0;
      seg_in    = seg_ff;
      vcount_in = vcount_ff;
      if (state_ff == ptpp_pkg::S_CLEAR) seg_in = '0;
      if (state_ff == ptpp_pkg::S_NEXT && !seg_last) seg_in = seg_ff + AW'(1);
      if (state_ff == ptpp_pkg::S_IDLE && req_valid) begin
         if (!req_mode || last_vertex) vcount_in = '0;
         else vcount_in = vcount_ff + AW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ptpp_pkg::S_IDLE;
         step_ff   <= '0;
         seg_ff    <= '0;
         vcount_ff <= '0;
      end else begin
         state_ff  <= state_in;
         step_ff   <= step_in;
         seg_ff    <= seg_in;
         vcount_ff <= vcount_in;
      end
   end

   `PTPP_ASSERT_NEXT(a_done_holds, (state_ff == ptpp_pkg::S_DONE) && !status.out_free, state_ff == ptpp_pkg::S_DONE, "result lost while output busy")
   `PTPP_ASSERT_NEXT(a_last_vertex_starts, (state_ff == ptpp_pkg::S_IDLE) && req_valid && req_mode && last_vertex, (state_ff == ptpp_pkg::S_CLEAR) && (vcount_ff == '0), "last vertex did not start evaluation")
   `PTPP_ASSERT(a_vcount_range, vcount_ff <= AW'(NUM_VERTS - 1), "vertex count out of range")

endmodule

`default_nettype wire

/* hdl/ptpp_dp.sv */
// ----------------------------------------------------------------------------
// ptpp_dp
// Projection datapath: vertex memory, shared multiplier, root and dividers.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module ptpp_dp #(
   parameter int NUM_SEGMENTS = 3,
   parameter int COORD_BITS   = 24,
   localparam int NUM_VERTS   = NUM_SEGMENTS + 1,
   localparam int AW          = $clog2(NUM_VERTS)
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire ptpp_pkg::cmd_type       cmd,
   input  wire logic [AW-1:0]           wr_addr,
   input  wire logic [AW-1:0]           rd_addr,
   input  wire logic [3*COORD_BITS-1:0] in_coords,
   input  wire logic                    rsp_ready,
   output logic                         rsp_valid,
   output logic [ptpp_pkg::POS_BITS-1:0] rsp_position,
   output logic                         rsp_degenerate,
   output ptpp_pkg::status_type         status
);

   localparam int CB        = COORD_BITS;
   localparam int PRE_SHIFT = (CB > 26) ? CB - 26 : 0;
   localparam int DW        = CB + 1 - PRE_SHIFT;
   localparam int L2W       = 2 * DW;
   localparam int PW        = 2 * DW + 2;
   localparam int ACW       = 2 * DW + 3;
   localparam int TW        = DW + $clog2(NUM_SEGMENTS + 1);
   localparam int BW        = TW + 16;
   localparam int NW        = TW + 17;

   // Coordinate difference, magnitude reduced to DW signed bits.
   function automatic logic signed [DW-1:0] red_diff(input logic signed [CB-1:0] a,
                                                     input logic signed [CB-1:0] b);
      logic signed [CB:0] df;
      logic [CB:0]        mag;
      logic [CB:0]        sh;
      df  = {a[CB-1], a} - {b[CB-1], b};
      mag = df[CB] ? (CB+1)'(-df) : (CB+1)'(df);
      sh  = mag >> PRE_SHIFT;
      return df[CB] ? -$signed(sh[DW-1:0]) : $signed(sh[DW-1:0]);
   endfunction

   logic [3*CB-1:0]        mem [NUM_VERTS];
   logic [3*CB-1:0]        rd_ff;
   logic [3*CB-1:0]        va_ff;
   logic signed [CB-1:0]   q_ff [3];
   logic signed [DW-1:0]   d_ff [3];
   logic signed [DW-1:0]   w_ff [3];
   logic signed [DW:0]     e_ff [3];
   logic signed [PW-1:0]   p_ff;
   logic signed [ACW-1:0]  acc_ff;
   logic [L2W-1:0]         l2_ff;
   logic [L2W-1:0]         sq_v_ff;
   logic [L2W-1:0]         sq_r_ff;
   logic [L2W-1:0]         sq_bit_ff;
   logic [16:0]            t_ff;
   logic [L2W:0]           fr_rem_ff;
   logic [TW-1:0]          total_ff;
   logic [PW-1:0]          best_d2_ff;
   logic [BW-1:0]          best_num_ff;
   logic                   have_ff;
   logic [NW-1:0]          dv_rem_ff;
   logic [NW-1:0]          dv_den_ff;
   logic [16:0]            dv_q_ff;
   logic                   rsp_valid_ff;
   logic [16:0]            pos_ff;
   logic                   degen_ff;

   logic [1:0]             iss;
   logic [1:0]             sc_idx;
   logic signed [DW:0]     mul_a, mul_b;
   logic [DW+16:0]         sc_sum;
   logic [DW-1:0]          sc_mag;
   logic signed [DW:0]     sc_off;
   logic signed [DW:0]     sc_e;
   logic [L2W:0]           sq_trial;
   logic [L2W:0]           fr_rem2;
   logic                   dot_pos;
   logic                   dot_ge;
   logic [DW-1:0]          len;
   logic                   better;

   assign len    = sq_r_ff[DW-1:0];
   assign iss    = (cmd.lane == 2'd3) ? 2'd0 : cmd.lane;
   assign sc_idx = (cmd.lane == 2'd0) ? 2'd0 : cmd.lane - 2'd1;

   // Shared multiplier operand selection.
   always_comb begin
      mul_a = {d_ff[iss][DW-1], d_ff[iss]};
      mul_b = {d_ff[iss][DW-1], d_ff[iss]};
      if (cmd.op == ptpp_pkg::OP_TLEN) begin
         mul_a = $signed({1'b0, len});
         mul_b = $signed({{(DW-16){1'b0}}, t_ff});
      end else begin
         unique case (cmd.mac)
            ptpp_pkg::MAC_L2: begin
               mul_a = {d_ff[iss][DW-1], d_ff[iss]};
               mul_b = {d_ff[iss][DW-1], d_ff[iss]};
            end
            ptpp_pkg::MAC_DOT: begin
               mul_a = {d_ff[iss][DW-1], d_ff[iss]};
               mul_b = {w_ff[iss][DW-1], w_ff[iss]};
            end
            ptpp_pkg::MAC_SCALE: begin
               mul_a = d_ff[iss][DW-1] ? -{d_ff[iss][DW-1], d_ff[iss]}
                                       :  {d_ff[iss][DW-1], d_ff[iss]};
               mul_b = $signed({{(DW-16){1'b0}}, t_ff});
            end
            ptpp_pkg::MAC_D2: begin
               mul_a = e_ff[iss];
               mul_b = e_ff[iss];
            end
            default: begin
               mul_a = '0;
               mul_b = '0;
            end
         endcase
      end
   end

   // Closest-point offset, rounded half away from zero, and the residual.
   always_comb begin
      sc_sum = {1'b0, p_ff[DW+15:0]} + (DW+17)'(ptpp_pkg::ROUND_Q16);
      sc_mag = sc_sum[DW+15:16];
      sc_off = d_ff[sc_idx][DW-1] ? -$signed({1'b0, sc_mag}) : $signed({1'b0, sc_mag});
      sc_e   = {w_ff[sc_idx][DW-1], w_ff[sc_idx]} - sc_off;
   end

   assign sq_trial = {1'b0, sq_r_ff} + {1'b0, sq_bit_ff};
   assign fr_rem2  = {fr_rem_ff[L2W-1:0], 1'b0};
   assign dot_pos  = !acc_ff[ACW-1] && (acc_ff != '0);
   assign dot_ge   = acc_ff[ACW-2:0] >= (ACW-1)'(l2_ff);
   assign better   = !have_ff || (acc_ff[PW-1:0] < best_d2_ff);

   // Vertex memory, registered read.
   always_ff @(posedge clock) begin
      if (cmd.op == ptpp_pkg::OP_VERTEX) mem[wr_addr] <= in_coords;
      rd_ff <= mem[rd_addr];
   end

   // Control and query registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 3; k++) q_ff[k] <= '0;
         have_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.op == ptpp_pkg::OP_QUERY) begin
            for (int k = 0; k < 3; k++) q_ff[k] <= in_coords[k*CB +: CB];
         end
         if (cmd.op == ptpp_pkg::OP_CLEAR) have_ff <= 1'b0;
         else if (cmd.op == ptpp_pkg::OP_COMPARE) have_ff <= 1'b1;
         if (cmd.op == ptpp_pkg::OP_OUT) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   // Arithmetic registers.
   always_ff @(posedge clock) begin
      p_ff <= mul_a * mul_b;
      unique case (cmd.op)
         ptpp_pkg::OP_CLEAR: begin
            total_ff <= '0;
         end
         ptpp_pkg::OP_LATCH_A: begin
            va_ff <= rd_ff;
         end
         ptpp_pkg::OP_LOAD: begin
            for (int k = 0; k < 3; k++) begin
               d_ff[k] <= red_diff(rd_ff[k*CB +: CB], va_ff[k*CB +: CB]);
               w_ff[k] <= red_diff(q_ff[k], va_ff[k*CB +: CB]);
            end
         end
         ptpp_pkg::OP_MAC: begin
            if (cmd.lane == 2'd0) acc_ff <= '0;
            else if (cmd.mac == ptpp_pkg::MAC_SCALE) e_ff[sc_idx] <= sc_e;
            else acc_ff <= acc_ff + ACW'(p_ff);
         end
         ptpp_pkg::OP_SQRT_INIT: begin
            l2_ff     <= acc_ff[L2W-1:0];
            sq_v_ff   <= acc_ff[L2W-1:0];
            sq_r_ff   <= '0;
            sq_bit_ff <= {2'b01, {(L2W-2){1'b0}}};
         end
         ptpp_pkg::OP_SQRT_STEP: begin
            if ({1'b0, sq_v_ff} >= sq_trial) begin
               sq_v_ff <= sq_v_ff - sq_trial[L2W-1:0];
               sq_r_ff <= (sq_r_ff >> 1) + sq_bit_ff;
            end else begin
               sq_r_ff <= sq_r_ff >> 1;
            end
            sq_bit_ff <= sq_bit_ff >> 2;
         end
         ptpp_pkg::OP_T_INIT: begin
            fr_rem_ff <= acc_ff[L2W:0];
            if (dot_pos && dot_ge) t_ff <= ptpp_pkg::POS_ONE;
            else t_ff <= '0;
         end
         ptpp_pkg::OP_FRAC_STEP: begin
            if (fr_rem2 >= {1'b0, l2_ff}) begin
               fr_rem_ff <= fr_rem2 - {1'b0, l2_ff};
               t_ff      <= {t_ff[15:0], 1'b1};
            end else begin
               fr_rem_ff <= fr_rem2;
               t_ff      <= {t_ff[15:0], 1'b0};
            end
         end
         ptpp_pkg::OP_COMPARE: begin
            if (better) begin
               best_d2_ff  <= acc_ff[PW-1:0];
               best_num_ff <= {total_ff, 16'h0000} + BW'(p_ff[DW+16:0]);
            end
         end
         ptpp_pkg::OP_NEXT: begin
            total_ff <= total_ff + TW'(len);
         end
         ptpp_pkg::OP_DIV_INIT: begin
            dv_rem_ff <= NW'(best_num_ff) + NW'(total_ff >> 1);
            dv_den_ff <= NW'({total_ff, 16'h0000});
            dv_q_ff   <= '0;
         end
         ptpp_pkg::OP_DIV_STEP: begin
            if (dv_rem_ff >= dv_den_ff) begin
               dv_rem_ff <= dv_rem_ff - dv_den_ff;
               dv_q_ff   <= {dv_q_ff[15:0], 1'b1};
            end else begin
               dv_q_ff   <= {dv_q_ff[15:0], 1'b0};
            end
            dv_den_ff <= dv_den_ff >> 1;
         end
         ptpp_pkg::OP_OUT: begin
            degen_ff <= (total_ff == '0);
            if (total_ff == '0) pos_ff <= '0;
            else if (dv_q_ff > ptpp_pkg::POS_ONE) pos_ff <= ptpp_pkg::POS_ONE;
            else pos_ff <= dv_q_ff;
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_position       = pos_ff;
   assign rsp_degenerate     = degen_ff;
   assign status.l2_zero     = (l2_ff == '0);
   assign status.frac_needed = dot_pos && !dot_ge;
   assign status.out_free    = !rsp_valid_ff || rsp_ready;

   `PTPP_ASSERT(a_pos_range, !rsp_valid_ff || (pos_ff <= ptpp_pkg::POS_ONE), "position above one")
   `PTPP_ASSERT(a_degen_zero, !(rsp_valid_ff && degen_ff) || (pos_ff == '0), "degenerate result with non-zero position")
   `PTPP_ASSERT_NEXT(a_out_loads, cmd.op == ptpp_pkg::OP_OUT, rsp_valid_ff, "result not presented after load")

endmodule

`default_nettype wire

/* hdl/point_to_polyline_projection.sv */
// ----------------------------------------------------------------------------
// point_to_polyline_projection
// Normalized arc-length position of the point of a polyline nearest a query.
// ----------------------------------------------------------------------------
// Usage. The req channel carries one transaction per point: req_tuser = 0
// loads the query point, req_tuser = 1 appends the next vertex. A query
// discards vertices gathered so far. When vertex NUM_SEGMENTS + 1 arrives,
// the block measures every segment and presents one transaction on the rsp
// channel: the position in Q1.16 (0 = first vertex, 65536 = last) and a flag
// that is set when the polyline has zero length, with position then 0.
// Operation. Queries and vertices other than the last are taken while idle.
// After the last vertex, each segment is read and its squared length summed
// on the shared multiplier; the square root then yields one result bit per
// cycle, DW bits in all, where DW = COORD_BITS + 1 (at most 27). A fraction
// is divided out only when the projection falls strictly inside the segment,
// and a segment of zero length skips the rest. A final division by the total
// gives the position; req_tready stays low meanwhile. The result sits in an
// output register, so the next polyline can be gathered and measured while a
// stalled receiver holds the previous one; if the receiver is still stalled
// when that next result is ready, the block waits with req_tready low until
// the output register is taken.
// Reset clears the query point to the origin, the vertex count and the
// output valid; vertex storage needs no clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module point_to_polyline_projection #(
   parameter int NUM_SEGMENTS = 3,
   parameter int COORD_BITS   = 24,
   localparam int REQ_W       = ((3 * COORD_BITS + 7) / 8) * 8
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_tvalid,
   output logic                             req_tready,
   input  wire logic [REQ_W-1:0]            req_tdata,   // x, y, z (signed Q3.20), zero fill
   input  wire logic                        req_tuser,   // mode: 0 query, 1 vertex
   output logic                             rsp_tvalid,
   input  wire logic                        rsp_tready,
   output logic [ptpp_pkg::RSP_W-1:0]       rsp_tdata,   // position (17 bits), zero fill
   output logic                             rsp_tuser    // degenerate
);

   localparam int NUM_VERTS = NUM_SEGMENTS + 1;
   localparam int AW        = $clog2(NUM_VERTS);
   localparam int PRE_SHIFT = (COORD_BITS > 26) ? COORD_BITS - 26 : 0;
   localparam int DW        = COORD_BITS + 1 - PRE_SHIFT;

   ptpp_pkg::cmd_type     cmd;
   ptpp_pkg::status_type  status;
   logic [AW-1:0]         wr_addr;
   logic [AW-1:0]         rd_addr;
   logic [ptpp_pkg::POS_BITS-1:0] position;

   // Sequencer: accepts transactions and steps through each segment.
   ptpp_ctrl #(
      .NUM_SEGMENTS (NUM_SEGMENTS),
      .SQRT_STEPS   (DW)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_mode  (req_tuser),
      .req_ready (req_tready),
      .status    (status),
      .cmd       (cmd),
      .wr_addr   (wr_addr),
      .rd_addr   (rd_addr)
   );

   // Datapath: vertex memory, multiplier, root, dividers and result register.
   ptpp_dp #(
      .NUM_SEGMENTS (NUM_SEGMENTS),
      .COORD_BITS   (COORD_BITS)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .wr_addr        (wr_addr),
      .rd_addr        (rd_addr),
      .in_coords      (req_tdata[3*COORD_BITS-1:0]),
      .rsp_ready      (rsp_tready),
      .rsp_valid      (rsp_tvalid),
      .rsp_position   (position),
      .rsp_degenerate (rsp_tuser),
      .status         (status)
   );

   assign rsp_tdata = {{(ptpp_pkg::RSP_W - ptpp_pkg::POS_BITS){1'b0}}, position};

endmodule

`default_nettype wire
